>>> rtl/core/aws_pkg.sv
// ----------------------------------------------------------------------------
// aws_pkg
// Shared types and constants for the waypoint stepper: ring geometry,
// request codes and the control groups passed between the ring and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package aws_pkg;

    localparam int WP_DEPTH = 16;
    localparam int PTR_W    = (WP_DEPTH > 1) ? $clog2(WP_DEPTH) : 1;
    localparam int CNT_W    = $clog2(WP_DEPTH + 1);

    // request codes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_STEP   = 1'b1;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic        [15:0] radius;
    } waypoint_t;

    typedef struct packed {
        logic      push;     // append a new waypoint at the tail
        logic      pop;      // head leaves the ring, count drops
        logic      recycle;  // old target goes to the tail, head advances
        waypoint_t wdata;
    } ring_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

    typedef struct packed {
        logic               take;        // head entry becomes the target
        logic               has_target;
        logic signed [15:0] desired_x;
        logic signed [15:0] desired_y;
    } step_res_t;

endpackage

`default_nettype wire

>>> rtl/core/aws_ring.sv
// ----------------------------------------------------------------------------
// aws_ring
// Waypoint ring: storage, head pointer and fill count. Reads the head entry
// and writes one entry at the tail per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aws_ring import aws_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  ring_ctrl_t ctrl,
    output waypoint_t  head_wp,
    output ring_stat_t stat
);

    localparam int SUM_W = CNT_W + 1;

    waypoint_t          slot_reg [WP_DEPTH];
    waypoint_t          head_wp_reg;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   head_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [SUM_W-1:0]   tail_sum;
    logic [PTR_W-1:0]   tail_idx;
    logic [PTR_W-1:0]   head_inc;
    logic               full;
    logic               wr_en;

    assign full     = (count_reg == CNT_W'(WP_DEPTH));
    assign tail_sum = {{(SUM_W - PTR_W){1'b0}}, head_reg} + {1'b0, count_reg};
    assign tail_idx = (tail_sum >= SUM_W'(WP_DEPTH)) ?
                      PTR_W'(tail_sum - SUM_W'(WP_DEPTH)) : PTR_W'(tail_sum);
    assign head_inc = (head_reg == PTR_W'(WP_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    // a full ring recycles into the slot the head just left
    assign wr_en    = (ctrl.push && !full) || ctrl.recycle;

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.push && !full) begin
            count_next = count_reg + 1'b1;
        end
        if (ctrl.pop) begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
        end
        if (ctrl.recycle) begin
            head_next = head_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[tail_idx] <= ctrl.wdata;
        end
    end

    // head entry for the next cycle; a write landing on the new head bypasses
    always_ff @(posedge aclk) begin
        if (wr_en && (tail_idx == head_next)) begin
            head_wp_reg <= ctrl.wdata;
        end else begin
            head_wp_reg <= slot_reg[head_next];
        end
    end

    assign head_wp    = head_wp_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = full;

endmodule

`default_nettype wire

>>> rtl/core/aws_move.sv
// ----------------------------------------------------------------------------
// aws_move
// Step datapath: arrival test on the current target, target selection and
// the rounded, saturated unit move toward the selected target.
// ----------------------------------------------------------------------------
`default_nettype none

module aws_move import aws_pkg::*; (
    input  logic signed [15:0] cur_x,
    input  logic signed [15:0] cur_y,
    input  waypoint_t          tgt,
    input  logic               tgt_valid,
    input  waypoint_t          head_wp,
    input  ring_stat_t         ring_stat,
    input  logic signed [15:0] last_x,
    input  logic signed [15:0] last_y,
    output step_res_t          res
);

    function automatic logic [15:0] mag17(input logic [16:0] d);
        logic [16:0] neg;
        begin
            neg    = -d;
            mag17  = d[16] ? neg[15:0] : d[15:0];
        end
    endfunction

    function automatic logic signed [15:0] step_axis(input logic signed [15:0] cur,
                                                     input logic neg,
                                                     input logic move);
        logic signed [16:0] inc;
        logic signed [16:0] sum;
        begin
            inc = move ? (neg ? -17'sd1 : 17'sd1) : 17'sd0;
            sum = {cur[15], cur} + inc;
            if (sum > 17'sd32767) begin
                step_axis = 16'sh7fff;
            end else if (sum < -17'sd32768) begin
                step_axis = 16'sh8000;
            end else begin
                step_axis = sum[15:0];
            end
        end
    endfunction

    logic [16:0] dxo, dyo, dxn, dyn;
    logic [31:0] sqxo, sqyo, sqxn, sqyn, r2;
    logic [32:0] len_o;
    logic [31:0] sqx, sqy;
    logic [33:0] sqx3;
    logic        reached;
    logic        take;
    logic        sel_valid;
    logic        negx, negy;
    logic        movex, movey;

    // squares for both the held target and the ring head, in parallel
    assign dxo  = {tgt.x[15], tgt.x} - {cur_x[15], cur_x};
    assign dyo  = {tgt.y[15], tgt.y} - {cur_y[15], cur_y};
    assign dxn  = {head_wp.x[15], head_wp.x} - {cur_x[15], cur_x};
    assign dyn  = {head_wp.y[15], head_wp.y} - {cur_y[15], cur_y};
    assign sqxo = mag17(dxo) * mag17(dxo);
    assign sqyo = mag17(dyo) * mag17(dyo);
    assign sqxn = mag17(dxn) * mag17(dxn);
    assign sqyn = mag17(dyn) * mag17(dyn);
    assign r2   = tgt.radius * tgt.radius;

    assign len_o     = {1'b0, sqxo} + {1'b0, sqyo};
    assign reached   = tgt_valid && (len_o < {1'b0, r2});
    assign take      = (reached || !tgt_valid) && !ring_stat.empty;
    assign sel_valid = tgt_valid || take;

    assign sqx  = take ? sqxn : sqxo;
    assign sqy  = take ? sqyn : sqyo;
    assign negx = take ? dxn[16] : dxo[16];
    assign negy = take ? dyn[16] : dyo[16];

    // round(d/len) is nonzero when 4*d^2 > dx^2+dy^2, i.e. 3*d^2 > other^2
    assign sqx3  = {2'b00, sqx} + {1'b0, sqx, 1'b0};
    assign movex = sqx3 > {2'b00, sqy};
    assign movey = ({2'b00, sqy} + {1'b0, sqy, 1'b0}) > {2'b00, sqx};

    always_comb begin
        res.take       = take;
        res.has_target = sel_valid;
        if (sel_valid) begin
            res.desired_x = step_axis(cur_x, negx, movex);
            res.desired_y = step_axis(cur_y, negy, movey);
        end else begin
            res.desired_x = last_x;
            res.desired_y = last_y;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/agent_waypoint_stepper.sv
// ----------------------------------------------------------------------------
// agent_waypoint_stepper
// Waypoint ring with target tracking; each step request returns one
// rounded unit move toward the current target, appends return nothing.
// ----------------------------------------------------------------------------
// a step passes the request register, then the result register
// throughput: one request per cycle unless a step is held back by m_ready, set by the
//   single-pass squarer datapath between the request and result registers
// reset: synchronous, active low; clears ring pointers, target and last
//   desired position; waypoint storage is not cleared
`default_nettype none

module agent_waypoint_stepper import aws_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic signed [15:0] s_wp_x,
    input  logic signed [15:0] s_wp_y,
    input  logic        [15:0] s_wp_radius,
    input  logic signed [15:0] s_cur_x,
    input  logic signed [15:0] s_cur_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_desired_x,
    output logic signed [15:0] m_desired_y,
    output logic               m_has_target
);

    logic               in_valid_reg;
    logic               op_reg;
    waypoint_t          wp_reg;
    logic signed [15:0] cur_x_reg;
    logic signed [15:0] cur_y_reg;

    waypoint_t          target_reg;
    logic               target_valid_reg;
    logic signed [15:0] last_x_reg;
    logic signed [15:0] last_y_reg;

    logic               out_valid_reg;
    logic signed [15:0] out_x_reg;
    logic signed [15:0] out_y_reg;
    logic               out_has_reg;

    logic               advance;
    logic               is_step;
    ring_ctrl_t         ring_ctrl;
    ring_stat_t         ring_stat;
    waypoint_t          head_wp;
    step_res_t          res;

    // appends never wait on the result side
    assign is_step = (op_reg == OP_STEP);
    assign advance = in_valid_reg && (!is_step || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            op_reg        <= s_op;
            wp_reg.x      <= s_wp_x;
            wp_reg.y      <= s_wp_y;
            wp_reg.radius <= s_wp_radius;
            cur_x_reg     <= s_cur_x;
            cur_y_reg     <= s_cur_y;
        end
    end

    aws_move u_move (
        .cur_x     (cur_x_reg),
        .cur_y     (cur_y_reg),
        .tgt       (target_reg),
        .tgt_valid (target_valid_reg),
        .head_wp   (head_wp),
        .ring_stat (ring_stat),
        .last_x    (last_x_reg),
        .last_y    (last_y_reg),
        .res       (res)
    );

    always_comb begin
        ring_ctrl.push    = advance && !is_step;
        ring_ctrl.pop     = advance && is_step && res.take && !target_valid_reg;
        ring_ctrl.recycle = advance && is_step && res.take && target_valid_reg;
        ring_ctrl.wdata   = is_step ? target_reg : wp_reg;
    end

    aws_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ring_ctrl),
        .head_wp (head_wp),
        .stat    (ring_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg       <= '0;
            target_valid_reg <= 1'b0;
            last_x_reg       <= '0;
            last_y_reg       <= '0;
        end else if (advance && is_step) begin
            if (res.take) begin
                target_reg       <= head_wp;
                target_valid_reg <= 1'b1;
            end
            last_x_reg <= res.desired_x;
            last_y_reg <= res.desired_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && is_step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && is_step) begin
            out_x_reg   <= res.desired_x;
            out_y_reg   <= res.desired_y;
            out_has_reg <= res.has_target;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_desired_x  = out_x_reg;
    assign m_desired_y  = out_y_reg;
    assign m_has_target = out_has_reg;

`ifndef SYNTHESIS
    // once a target is held it is never dropped
    a_target_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> !$fell(target_valid_reg))
        else $error("target lost after being taken");

    // a result claiming a target implies the target register is loaded
    a_has_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_has_target) |-> target_valid_reg)
        else $error("has_target without a held target");

    // an append to a full ring leaves it full
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (ring_ctrl.push && ring_stat.full) |=> ring_stat.full)
        else $error("append to full ring changed fill");

    // a step that takes the head needs a waiting waypoint
    a_take_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (ring_ctrl.pop || ring_ctrl.recycle) |-> !ring_stat.empty)
        else $error("head taken from empty ring");
`endif

endmodule

`default_nettype wire
